// ===== sv/pgbd_pkg.sv =====
// Shared types, codes and address helpers for the palette grid block decoder.
package pgbd_pkg;

	localparam int unsigned GRID_BLOCKS = 64;
	localparam int unsigned RAW_BYTES   = 128;

	localparam logic [7:0] UNIFORM_CODE = 8'd7;
	localparam logic       OP_HEADER    = 1'b0;
	localparam logic       OP_DATA      = 1'b1;
	localparam logic [1:0] FMT_RAW      = 2'b11;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// Where emitted block values come from
	typedef enum logic [1:0] {
		SRC_FILL = 2'd0,
		SRC_RAW  = 2'd1,
		SRC_PAL  = 2'd2
	} src_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // take the input transaction
		logic emit;   // produce one block into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rem_zero;
		logic rem_one;
		logic out_free;
	} status_t;

	// Grid base: g = {row[3:0], col[4:0]}; (row/4)*64 + (row%4)*4 + col*1024 + sec*32768
	function automatic logic [15:0] grid_base(input logic [8:0] g, input logic sec);
		grid_base = {sec, g[4:0], 2'b00, g[8:7], 2'b00, g[6:5], 2'b00};
	endfunction

	// Block n = 16i + 4j + k lands at 16i + j + 256k
	function automatic logic [15:0] block_offset(input logic [5:0] n);
		block_offset = {6'd0, n[1:0], 2'b00, n[5:4], 2'b00, n[3:2]};
	endfunction

	// Bytes in a packed grid: palette plus packed indexes
	function automatic logic [7:0] packed_total(input logic [1:0] fmt);
		case (fmt)
			2'd0:    packed_total = 8'd10;
			2'd1:    packed_total = 8'd20;
			default: packed_total = 8'd48;
		endcase
	endfunction

endpackage

// ===== sv/pgbd_ctrl.sv =====
// Controller state machine: takes an item, then steps out its blocks.
module pgbd_ctrl
	import pgbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nx;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.rem_zero) begin
					state_nx = ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.rem_one)
						state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

`ifndef SYNTHESIS
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("emit into occupied output register");
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && status.rem_zero) |=> state_q == ST_IDLE)
		else $error("controller stuck after blocks done");
	a_ready_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (state_q == ST_IDLE)) else $error("ready outside idle state");
`endif

endmodule

// ===== sv/pgbd_dp.sv =====
// Datapath: grid context, palette, block counter and output register.
module pgbd_dp
	import pgbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        opcode,
	input  logic [7:0]  header_code,
	input  logic [7:0]  header_value,
	input  logic [8:0]  grid_index,
	input  logic        section,
	input  logic [7:0]  data_byte,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  block_value,
	output logic [15:0] block_address,
	output logic        last_of_grid
);

	logic        open_q;
	logic [1:0]  fmt_q;
	logic [7:0]  bytes_q;
	logic [6:0]  blocks_q;
	logic [15:0] base_q;
	logic [6:0]  rem_q;
	src_t        src_q;
	logic [7:0]  byte_q;
	logic [7:0]  palette_q [16];

	logic        out_valid_q;
	logic [7:0]  out_value_q;
	logic [15:0] out_addr_q;
	logic        out_last_q;

	logic [7:0]  bytes_nx;
	logic [7:0]  pal_size;
	logic [3:0]  idx_mask;
	logic [7:0]  emit_value;
	logic [7:0]  byte_shifted;
	logic [5:0]  blk_n;

	assign bytes_nx = bytes_q + 8'd1;
	assign blk_n    = blocks_q[5:0];

	// Palette geometry for the current packed format
	always_comb begin
		case (fmt_q)
			2'd0: begin
				pal_size     = 8'd2;
				idx_mask     = 4'h1;
				byte_shifted = {1'b0, byte_q[7:1]};
			end
			2'd1: begin
				pal_size     = 8'd4;
				idx_mask     = 4'h3;
				byte_shifted = {2'b00, byte_q[7:2]};
			end
			default: begin
				pal_size     = 8'd16;
				idx_mask     = 4'hf;
				byte_shifted = {4'h0, byte_q[7:4]};
			end
		endcase
	end

	// Value of the block going out now
	always_comb begin
		case (src_q)
			SRC_PAL: emit_value = palette_q[byte_q[3:0] & idx_mask];
			default: emit_value = byte_q;
		endcase
	end

	// Grid context and emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			fmt_q    <= 2'd0;
			bytes_q  <= 8'd0;
			blocks_q <= 7'd0;
			base_q   <= 16'd0;
			rem_q    <= 7'd0;
			src_q    <= SRC_FILL;
		end else if (cmd.load) begin
			if (opcode == OP_HEADER) begin
				base_q   <= grid_base(grid_index, section);
				bytes_q  <= 8'd0;
				blocks_q <= 7'd0;
				if (header_code == UNIFORM_CODE) begin
					open_q <= 1'b0;
					src_q  <= SRC_FILL;
					rem_q  <= 7'(GRID_BLOCKS);
				end else begin
					open_q <= 1'b1;
					fmt_q  <= header_code[1:0];
					rem_q  <= 7'd0;
				end
			end else if (!open_q) begin
				rem_q <= 7'd0;
			end else if (fmt_q == FMT_RAW) begin
				bytes_q <= bytes_nx;
				src_q   <= SRC_RAW;
				rem_q   <= bytes_q[0] ? 7'd0 : 7'd1;
				if (bytes_nx >= 8'(RAW_BYTES))
					open_q <= 1'b0;
			end else begin
				bytes_q <= bytes_nx;
				src_q   <= SRC_PAL;
				if (bytes_q < pal_size)
					rem_q <= 7'd0;
				else
					rem_q <= 7'd8 >> fmt_q;
				if (bytes_nx >= packed_total(fmt_q))
					open_q <= 1'b0;
			end
		end else if (cmd.emit) begin
			rem_q    <= rem_q - 7'd1;
			blocks_q <= blocks_q + 7'd1;
		end
	end

	// Data byte holder; packed indexes shift out low bits first
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (opcode == OP_HEADER)
				byte_q <= header_value;
			else if (open_q)
				byte_q <= data_byte;
		end else if (cmd.emit && src_q == SRC_PAL) begin
			byte_q <= byte_shifted;
		end
	end

	// Palette writes
	always_ff @(posedge clk) begin
		if (cmd.load && opcode == OP_DATA && open_q && fmt_q != FMT_RAW && bytes_q < pal_size)
			palette_q[bytes_q[3:0]] <= data_byte;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= emit_value;
			out_addr_q  <= base_q + block_offset(blk_n);
			out_last_q  <= (blk_n == 6'(GRID_BLOCKS - 1));
		end
	end

	assign out_valid       = out_valid_q;
	assign block_value     = out_value_q;
	assign block_address   = out_addr_q;
	assign last_of_grid    = out_last_q;
	assign status.rem_zero = (rem_q == 7'd0);
	assign status.rem_one  = (rem_q == 7'd1);
	assign status.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_no_load_and_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.emit)) else $error("load and emit in one cycle");
	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 7'(GRID_BLOCKS)) else $error("block count out of range");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && blk_n == 6'(GRID_BLOCKS - 1)) |=> rem_q == 7'd0)
		else $error("blocks pending after last block of grid");
`endif

endmodule

// ===== sv/palette_grid_block_decoder_top.sv =====
// Top level of the palette grid block decoder.
// Decodes 64-block grids into addressed block values. A header transaction
// (tuser 0) opens a grid; code 7 emits 64 copies of the value byte.
// Data transactions (tuser 1) carry palette, packed-index or raw bytes. Rate:
// the decoder takes one input transaction at a time. An item that yields N
// blocks sends them one block per cycle from the output register, but for any
// stall on m_tready (N is 1 for an even-numbered raw byte and 0 for an odd one,
// 0 for a palette byte, 8/4/2 for the 1/2/4-bit packed formats, 64 for a
// uniform grid). The next transaction is taken as soon as the last block sits
// in the output register. Palette entries that were never written read as undefined.
module palette_grid_block_decoder_top
	import pgbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // header_code, header_value, grid_index, section, data_byte, pad
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // block_value, block_address
	output logic        m_tlast    // last_of_grid
);

	cmd_t    cmd;
	status_t status;
	logic [7:0]  block_value;
	logic [15:0] block_address;

	pgbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pgbd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.opcode        (s_tuser),
		.header_code   (s_tdata[7:0]),
		.header_value  (s_tdata[15:8]),
		.grid_index    (s_tdata[24:16]),
		.section       (s_tdata[25]),
		.data_byte     (s_tdata[33:26]),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.block_value   (block_value),
		.block_address (block_address),
		.last_of_grid  (m_tlast)
	);

	assign m_tdata = {block_address, block_value};

endmodule

// ===== tb/sv/palette_grid_block_decoder_top_test.sv =====
// Testbench for the palette grid block decoder: directed and random grids, scoreboard checking.
`timescale 1ns / 100ps

module palette_grid_block_decoder_top_test
	import pgbd_pkg::*;
();

	localparam int unsigned IDLE_LIMIT   = 1000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_ITEMS = 320;

	// One expected block leaving the decoder
	typedef struct packed {
		logic [7:0]  value;
		logic [15:0] addr;
		logic        last;
	} block_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // header_code, header_value, grid_index, section, data_byte, pad
	logic        s_tuser;   // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // block_value, block_address
	logic        m_tlast;   // last_of_grid

	// Decoder state as the scoreboard sees it
	logic        grid_is_open;
	logic [1:0]  grid_fmt;
	logic [7:0]  palette [16];
	logic [7:0]  grid_bytes;
	logic [6:0]  grid_blocks_out;
	logic [15:0] grid_base_addr;

	block_t      expected_blocks [$];
	int unsigned mismatches = 0;
	int unsigned grid_items_sent;
	int unsigned idle_cycles = 0;
	bit          send_gaps;
	bit          recv_stalls;

	palette_grid_block_decoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Queue one block at the scattered address of the next position in the grid
	function automatic void push_block(input logic [7:0] value);
		block_t      blk;
		int unsigned n;
		n         = int'(grid_blocks_out) % 64;
		blk.value = value;
		blk.addr  = 16'(int'(grid_base_addr) + (n / 16) * 16 + (n / 4) % 4 + (n % 4) * 256);
		blk.last  = (n == GRID_BLOCKS - 1);
		expected_blocks.push_back(blk);
		grid_blocks_out = grid_blocks_out + 7'd1;
	endfunction

	// Advance the scoreboard state by one input transaction; returns 0 if it is ignored
	function automatic bit decode_item(input logic op, input logic [7:0] code,
			input logic [7:0] value, input logic [8:0] g, input logic sec,
			input logic [7:0] data);
		int unsigned pos;
		int unsigned bits;
		int unsigned pal_size;
		int unsigned total;
		int unsigned idx;
		if (op == OP_HEADER) begin
			grid_base_addr  = 16'((int'(g) / 128) * 64 + ((int'(g) / 32) % 4) * 4
				+ (int'(g) % 32) * 1024 + int'(sec) * 32768);
			grid_bytes      = 8'd0;
			grid_blocks_out = 7'd0;
			if (code == UNIFORM_CODE) begin
				for (int k = 0; k < GRID_BLOCKS; k++)
					push_block(value);
				grid_is_open = 1'b0;
			end else begin
				grid_fmt     = code[1:0];
				grid_is_open = 1'b1;
			end
			return 1'b1;
		end
		if (!grid_is_open)
			return 1'b0;
		pos        = grid_bytes;
		grid_bytes = grid_bytes + 8'd1;
		if (grid_fmt == FMT_RAW) begin
			// odd raw bytes are consumed and dropped
			if (pos % 2 == 0)
				push_block(data);
			if (grid_bytes >= RAW_BYTES)
				grid_is_open = 1'b0;
		end else begin
			bits     = 1 << grid_fmt;
			pal_size = 1 << bits;
			total    = pal_size + 8 * bits;
			if (pos < pal_size) begin
				palette[pos % 16] = data;
			end else begin
				// indexes least significant first
				for (int j = 0; j < 8 / bits; j++) begin
					idx = (int'(data) >> (j * bits)) & (pal_size - 1);
					push_block(palette[idx]);
				end
			end
			if (grid_bytes >= total)
				grid_is_open = 1'b0;
		end
		return 1'b1;
	endfunction

	// Drive one input transaction, wait for it to be taken, predict its blocks.
	// Returns at the following falling edge with tvalid still high.
	task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] value,
			input logic [8:0] g, input logic sec, input logic [7:0] data);
		int unsigned gap;
		gap = send_gaps ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= {6'd0, data, sec, g, value, code};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (decode_item(op, code, value, g, sec, data))
			grid_items_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [7:0] code, input logic [7:0] value,
			input logic [8:0] g, input logic sec);
		send_item(OP_HEADER, code, value, g, sec, 8'($urandom));
	endtask

	// Header fields are don't-care on data transactions, so randomise them
	task automatic send_data(input logic [7:0] data);
		send_item(OP_DATA, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom), data);
	endtask

	// Random non-uniform header code for a given format
	function automatic logic [7:0] format_code(input logic [1:0] fmt);
		logic [7:0] code;
		code = {6'($urandom), fmt};
		if (code == UNIFORM_CODE)
			code = {6'h3f, fmt};
		return code;
	endfunction

	function automatic int unsigned grid_length(input logic [1:0] fmt);
		if (fmt == FMT_RAW)
			return RAW_BYTES;
		return (1 << (1 << fmt)) + 8 * (1 << fmt);
	endfunction

	// Data before any grid has been opened is dropped
	task automatic test_no_open_grid();
		send_data(8'hff);
	endtask

	// Uniform grids at both ends of the address range
	task automatic test_uniform_grids();
		send_header(UNIFORM_CODE, 8'hff, 9'd511, 1'b1);
		send_header(UNIFORM_CODE, 8'h00, 9'd0, 1'b0);
	endtask

	// Complete one-bit grid, then a stray byte after completion
	task automatic test_one_bit_grid();
		logic [7:0] packed_bytes [8];
		packed_bytes = '{8'h00, 8'hff, 8'ha5, 8'h5a, 8'h01, 8'h80, 8'h0f, 8'hf0};
		send_header(8'h00, 8'h3c, 9'd300, 1'b1);
		send_data(8'h00);
		send_data(8'hff);
		foreach (packed_bytes[i])
			send_data(packed_bytes[i]);
		send_data(8'h55);
	endtask

	// Headers that abandon open grids; codes whose low bits alone pick the format
	task automatic test_grid_switching();
		send_header(8'hfe, 8'h11, 9'd37, 1'b0);
		send_data(8'h12);
		send_data(8'h34);
		send_header(8'h87, 8'h22, 9'd128, 1'b1);
		send_data(8'hab);
		send_data(8'hcd);
		send_data(8'hef);
		send_header(UNIFORM_CODE, 8'h99, 9'd255, 1'b0);
		send_header(8'hfc, 8'h00, 9'd64, 1'b1);
		send_data(8'h77);
	endtask

	// Mostly complete grids of random content, with uniform grids, broken grids and noise
	task automatic test_random_grids(input int unsigned goal);
		int unsigned pick;
		int unsigned len;
		logic [1:0]  fmt;
		while (grid_items_sent < goal) begin
			pick = $urandom_range(0, 99);
			fmt  = 2'($urandom);
			if (pick < 12) begin
				send_header(UNIFORM_CODE, 8'($urandom), 9'($urandom), 1'($urandom));
			end else if (pick < 24) begin
				// broken grid: cut short by whatever comes next
				len = $urandom_range(0, grid_length(fmt) - 1);
				send_header(format_code(fmt), 8'($urandom), 9'($urandom), 1'($urandom));
				repeat (len) send_data(8'($urandom));
			end else begin
				send_header(format_code(fmt), 8'($urandom), 9'($urandom), 1'($urandom));
				repeat (grid_length(fmt)) send_data(8'($urandom));
				// stray bytes after completion
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) send_data(8'($urandom));
			end
		end
	endtask

	// Result side: random stall before each block, then check it against the oldest expectation
	initial begin
		block_t      want;
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_stalls ? $urandom_range(0, 16) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			if (expected_blocks.size() == 0) begin
				report_mismatch($sformatf("unexpected block value %0h addr %0h",
					m_tdata[7:0], m_tdata[23:8]));
			end else begin
				want = expected_blocks.pop_front();
				if (m_tdata[7:0] !== want.value)
					report_mismatch($sformatf("block_value %0h, want %0h",
						m_tdata[7:0], want.value));
				if (m_tdata[23:8] !== want.addr)
					report_mismatch($sformatf("block_address %0h, want %0h",
						m_tdata[23:8], want.addr));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_of_grid %0b, want %0b",
						m_tlast, want.last));
			end
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tuser         = 1'b0;
		s_tdata         = '0;
		grid_is_open    = 1'b0;
		grid_fmt        = 2'd0;
		grid_bytes      = 8'd0;
		grid_blocks_out = 7'd0;
		grid_base_addr  = 16'd0;
		foreach (palette[i])
			palette[i] = 8'd0;
		grid_items_sent = 0;
		send_gaps       = 1'b1;
		recv_stalls     = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_open_grid();
		test_uniform_grids();
		test_one_bit_grid();
		test_grid_switching();

		// random part in four idling modes, including a stretch with none
		grid_items_sent = 0;
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		test_random_grids(RANDOM_ITEMS / 4);
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
		test_random_grids(RANDOM_ITEMS / 2);
		send_gaps   = 1'b1;
		recv_stalls = 1'b0;
		test_random_grids(3 * RANDOM_ITEMS / 4);
		send_gaps   = 1'b0;
		recv_stalls = 1'b1;
		test_random_grids(RANDOM_ITEMS);

		// drain the outstanding blocks
		s_tvalid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
